// File: design/depth_pixel_back_projection_assert.svh
// assertion macros for the depth pixel back projection checker
`ifndef DEPTH_PIXEL_BACK_PROJECTION_ASSERT_SVH
`define DEPTH_PIXEL_BACK_PROJECTION_ASSERT_SVH

// concurrent assertion, switched off while reset is high
`define DPBP_ASSERT_RST(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error(msg);

// concurrent assertion that also holds through reset
`define DPBP_ASSERT(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// File: design/dpbp_pkg.sv
// types and constants for the depth pixel back projection block
`timescale 1ns / 1ps

package dpbp_pkg;

  localparam int DEPTH_W     = 16;
  localparam int CENTER_W    = 16;
  localparam int RECIP_W     = 24;
  localparam int COLOR_W     = 8;
  localparam int PCOLOR_W    = 3 * COLOR_W;
  localparam int POINT_W     = 32;
  localparam int FRAC_BITS   = 24;
  localparam int SUBPIX_BITS = 4;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_IDX_W   = 3;

  // rising edges from the accepting edge to the edge that takes the result
  localparam int LATENCY     = 5;

  typedef logic [REG_IDX_W-1:0] reg_index_t;

  localparam reg_index_t REG_CENTER_X      = 3'd0;
  localparam reg_index_t REG_CENTER_Y      = 3'd1;
  localparam reg_index_t REG_RECIP_FOCAL_X = 3'd2;
  localparam reg_index_t REG_RECIP_FOCAL_Y = 3'd3;
  localparam reg_index_t REG_DEPTH_LIMIT   = 3'd4;
  localparam reg_index_t REG_AXIS_SWAP     = 3'd5;

  localparam logic [CENTER_W-1:0] CENTER_X_RST    = 16'd5120;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST    = 16'd3840;
  localparam logic [RECIP_W-1:0]  RECIP_FOCAL_RST = 24'd33554;
  localparam logic [DEPTH_W-1:0]  DEPTH_LIMIT_RST = 16'd20000;

  // per-pixel data that rides alongside the multiplier pipes
  typedef struct packed {
    logic                in_range;
    logic [DEPTH_W-1:0]  depth;
    logic [PCOLOR_W-1:0] color;
  } pixel_side_t;

endpackage

// File: design/dpbp_scale.sv
// three-stage floor(diff * depth * recip / 2^24) pipe for one axis
`timescale 1ns / 1ps

module dpbp_scale import dpbp_pkg::*; #(
  parameter int DIFF_W = 17
) (
  input  logic                                   clk,
  input  logic signed [DIFF_W-1:0]               diff,
  input  logic        [DEPTH_W-1:0]              depth,
  input  logic        [RECIP_W-1:0]              recip,
  output logic signed [DIFF_W-1+DEPTH_W:0]       floor_val
);

  localparam int MAG_W  = DIFF_W - 1;
  localparam int PART_W = MAG_W + DEPTH_W;
  localparam int PROD_W = PART_W + RECIP_W;

  logic [DIFF_W-1:0] diff_abs;
  logic [MAG_W-1:0]  mag;
  logic              neg2;
  logic              neg3;
  logic [PART_W-1:0] part;
  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   prod_signed;

  // diff never reaches the most negative code, so the magnitude fits MAG_W
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign mag      = diff_abs[MAG_W-1:0];

  always_ff @(posedge clk) begin
    neg2 <= diff[DIFF_W-1];
    part <= mag * depth;
  end

  always_ff @(posedge clk) begin
    neg3 <= neg2;
    prod <= part * recip;
  end

  // negate then arithmetic shift gives the floor for both signs
  assign prod_signed = neg3 ? (PROD_W+1)'(-{1'b0, prod}) : {1'b0, prod};

  always_ff @(posedge clk) begin
    floor_val <= prod_signed[PROD_W:FRAC_BITS];
  end

endmodule

// File: design/depth_pixel_back_projection.sv
// top level of the depth pixel back projection pipeline
`timescale 1ns / 1ps

// Back-projects one depth pixel per clock into a 3d point in 1/16 mm.
// Input: a pixel is accepted at a rising edge where start is high and busy
//   is low. busy is high only while rst is asserted, so a new pixel may be
//   offered in every cycle.
// Output: done is high with point_x/y/z, point_valid and packed_color
//   for each result; the receiver has no way to stall and must take it.
// Pipeline: input register, two multiplier stages, floor stage, saturate
//   and output register.
// Throughput: one pixel per cycle, set by the fully pipelined
//   multiplier chain per axis.
// Configuration: APB registers at byte address 4*index, written in the
//   access cycle; pready is tied high. Change them only while no pixel is
//   in flight.
// Reset: synchronous rst clears the pipeline valid bits and the output
//   strobe and loads every register with its default.

module depth_pixel_back_projection import dpbp_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_W-1:0]     paddr,
  input  logic [CFG_DATA_W-1:0]     pwdata,
  output logic [CFG_DATA_W-1:0]     prdata,
  output logic                      pready,
  input  logic                      start,
  output logic                      busy,
  input  logic [COORD_BITS-1:0]     column,
  input  logic [COORD_BITS-1:0]     row,
  input  logic [DEPTH_W-1:0]        depth_mm,
  input  logic [COLOR_W-1:0]        red,
  input  logic [COLOR_W-1:0]        green,
  input  logic [COLOR_W-1:0]        blue,
  output logic                      done,
  output logic signed [POINT_W-1:0] point_x,
  output logic signed [POINT_W-1:0] point_y,
  output logic signed [POINT_W-1:0] point_z,
  output logic                      point_valid,
  output logic [PCOLOR_W-1:0]       packed_color
);

  localparam int SHIFTED_W = COORD_BITS + SUBPIX_BITS;
  localparam int DIFF_W    = ((SHIFTED_W > CENTER_W) ? SHIFTED_W : CENTER_W) + 1;
  localparam int FLOOR_W   = DIFF_W + DEPTH_W;
  localparam int SIDE_DEPTH = 4;

  localparam logic signed [FLOOR_W:0] PT_MAX =
    {{(FLOOR_W + 2 - POINT_W){1'b0}}, {(POINT_W - 1){1'b1}}};
  localparam logic signed [FLOOR_W:0] PT_MIN =
    {{(FLOOR_W + 2 - POINT_W){1'b1}}, {(POINT_W - 1){1'b0}}};

  // configuration registers
  logic [CENTER_W-1:0] center_x;
  logic [CENTER_W-1:0] center_y;
  logic [RECIP_W-1:0]  recip_focal_x;
  logic [RECIP_W-1:0]  recip_focal_y;
  logic [DEPTH_W-1:0]  depth_limit;
  logic                axis_swap;

  reg_index_t cfg_index;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_index = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= CENTER_X_RST;
      center_y      <= CENTER_Y_RST;
      recip_focal_x <= RECIP_FOCAL_RST;
      recip_focal_y <= RECIP_FOCAL_RST;
      depth_limit   <= DEPTH_LIMIT_RST;
      axis_swap     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_X:      center_x      <= pwdata[CENTER_W-1:0];
        REG_CENTER_Y:      center_y      <= pwdata[CENTER_W-1:0];
        REG_RECIP_FOCAL_X: recip_focal_x <= pwdata[RECIP_W-1:0];
        REG_RECIP_FOCAL_Y: recip_focal_y <= pwdata[RECIP_W-1:0];
        REG_DEPTH_LIMIT:   depth_limit   <= pwdata[DEPTH_W-1:0];
        REG_AXIS_SWAP:     axis_swap     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_CENTER_X:      prdata = {{(CFG_DATA_W - CENTER_W){1'b0}}, center_x};
      REG_CENTER_Y:      prdata = {{(CFG_DATA_W - CENTER_W){1'b0}}, center_y};
      REG_RECIP_FOCAL_X: prdata = {{(CFG_DATA_W - RECIP_W){1'b0}}, recip_focal_x};
      REG_RECIP_FOCAL_Y: prdata = {{(CFG_DATA_W - RECIP_W){1'b0}}, recip_focal_y};
      REG_DEPTH_LIMIT:   prdata = {{(CFG_DATA_W - DEPTH_W){1'b0}}, depth_limit};
      REG_AXIS_SWAP:     prdata = {{(CFG_DATA_W - 1){1'b0}}, axis_swap};
      default:           prdata = '0;
    endcase
  end

  // input stage
  logic                     accept;
  logic signed [DIFF_W-1:0] dx_in;
  logic signed [DIFF_W-1:0] dy_in;
  pixel_side_t              side_in;

  assign busy   = rst;
  assign accept = start && !busy;

  assign dx_in = $signed({{(DIFF_W - SHIFTED_W){1'b0}}, column, {SUBPIX_BITS{1'b0}}})
               - $signed({{(DIFF_W - CENTER_W){1'b0}}, center_x});
  assign dy_in = $signed({{(DIFF_W - SHIFTED_W){1'b0}}, row, {SUBPIX_BITS{1'b0}}})
               - $signed({{(DIFF_W - CENTER_W){1'b0}}, center_y});

  assign side_in.in_range = (depth_mm != '0) && (depth_mm <= depth_limit);
  assign side_in.depth    = depth_mm;
  assign side_in.color    = {red, green, blue};

  logic signed [DIFF_W-1:0] s1_dx;
  logic signed [DIFF_W-1:0] s1_dy;
  logic [SIDE_DEPTH-1:0]    stage_valid;
  pixel_side_t              side [SIDE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= {stage_valid[SIDE_DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    s1_dx   <= dx_in;
    s1_dy   <= dy_in;
    side[0] <= side_in;
    for (int i = 1; i < SIDE_DEPTH; i++) begin
      side[i] <= side[i-1];
    end
  end

  // per-axis multiply and floor
  logic signed [FLOOR_W-1:0] floor_x;
  logic signed [FLOOR_W-1:0] floor_y;

  dpbp_scale #(.DIFF_W(DIFF_W)) u_scale_x (
    .clk       (clk),
    .diff      (s1_dx),
    .depth     (side[0].depth),
    .recip     (recip_focal_x),
    .floor_val (floor_x)
  );

  dpbp_scale #(.DIFF_W(DIFF_W)) u_scale_y (
    .clk       (clk),
    .diff      (s1_dy),
    .depth     (side[0].depth),
    .recip     (recip_focal_y),
    .floor_val (floor_y)
  );

  // output stage: zero for out-of-range depth, else optional swap with negation, then clamp
  function automatic logic [POINT_W-1:0] sat_point(input logic signed [FLOOR_W:0] v);
    logic [POINT_W-1:0] res;
    if (v > PT_MAX) begin
      res = PT_MAX[POINT_W-1:0];
    end else if (v < PT_MIN) begin
      res = PT_MIN[POINT_W-1:0];
    end else begin
      res = v[POINT_W-1:0];
    end
    return res;
  endfunction

  logic signed [FLOOR_W:0] x_ext;
  logic signed [FLOOR_W:0] y_ext;
  logic [POINT_W-1:0]      z_scaled;
  logic [POINT_W-1:0]      x_next;
  logic [POINT_W-1:0]      y_next;
  logic [POINT_W-1:0]      z_next;

  assign x_ext    = {floor_x[FLOOR_W-1], floor_x};
  assign y_ext    = {floor_y[FLOOR_W-1], floor_y};
  assign z_scaled = {{(POINT_W - DEPTH_W - SUBPIX_BITS){1'b0}},
                     side[SIDE_DEPTH-1].depth, {SUBPIX_BITS{1'b0}}};

  always_comb begin
    if (!side[SIDE_DEPTH-1].in_range) begin
      x_next = '0;
      y_next = '0;
      z_next = '0;
    end else if (axis_swap) begin
      x_next = z_scaled;
      y_next = sat_point((FLOOR_W+1)'(-x_ext));
      z_next = sat_point((FLOOR_W+1)'(-y_ext));
    end else begin
      x_next = sat_point(x_ext);
      y_next = sat_point(y_ext);
      z_next = z_scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid[SIDE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid[SIDE_DEPTH-1]) begin
      point_x      <= x_next;
      point_y      <= y_next;
      point_z      <= z_next;
      point_valid  <= side[SIDE_DEPTH-1].in_range;
      packed_color <= side[SIDE_DEPTH-1].color;
    end
  end

endmodule

// File: design/dpbp_checker.sv
// port-level checks for the depth pixel back projection block, bound to the top
`timescale 1ns / 1ps
`include "depth_pixel_back_projection_assert.svh"

module dpbp_checker import dpbp_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic signed [POINT_W-1:0] point_x,
  input logic signed [POINT_W-1:0] point_y,
  input logic signed [POINT_W-1:0] point_z,
  input logic                      point_valid
);

  // every accepted pixel gives a strobe after the fixed latency
  `DPBP_ASSERT_RST(a_result_follows, clk, rst, start && !busy |-> ##LATENCY done, "accepted pixel produced no result")

  // no strobe without a pixel accepted at the matching edge
  `DPBP_ASSERT_RST(a_no_extra_result, clk, rst, done |-> $past(start && !busy, LATENCY), "result without an accepted pixel")

  // out-of-range depth reports the origin
  `DPBP_ASSERT(a_invalid_zero, clk, done && !point_valid |-> point_x == 0 && point_y == 0 && point_z == 0, "invalid point with nonzero coordinates")

  // a valid point carries the depth axis as a positive multiple of 16
  `DPBP_ASSERT_RST(a_depth_axis, clk, rst, done && point_valid |-> (!point_z[POINT_W-1] && point_z != 0 && point_z[3:0] == 0) || (!point_x[POINT_W-1] && point_x != 0 && point_x[3:0] == 0), "valid point without a depth axis")

endmodule

bind depth_pixel_back_projection dpbp_checker u_dpbp_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .point_x     (point_x),
  .point_y     (point_y),
  .point_z     (point_z),
  .point_valid (point_valid)
);

// File: tb/tb.sv
// self-checking testbench for the depth pixel back projection pipeline
`timescale 1ns / 1ps

module tb;
  import dpbp_pkg::*;

  localparam int COORD_BITS     = 12;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int PHASE_RANDOM   = 100;
  localparam int RANDOM_PHASES  = 11;
  localparam longint POINT_MAX  = 64'sd2147483647;
  localparam longint POINT_MIN  = -64'sd2147483648;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic [DEPTH_W-1:0]    depth;
    logic [COLOR_W-1:0]    red;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    blue;
  } pixel_t;

  typedef struct packed {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic signed [POINT_W-1:0] z;
    logic                      valid;
    logic [PCOLOR_W-1:0]       color;
  } point_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [RECIP_W-1:0]  recip_x;
    logic [RECIP_W-1:0]  recip_y;
    logic [DEPTH_W-1:0]  depth_limit;
    logic                axis_swap;
  } camera_cfg_t;

  // typed = 1: the expected point is the one in the row
  typedef struct packed {
    pixel_t px;
    logic   typed;
    point_t want;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 13;
  localparam int PRESET_PHASES = 5;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]     paddr = '0;
  logic [CFG_DATA_W-1:0]     pwdata = '0;
  logic [CFG_DATA_W-1:0]     prdata;
  logic                      pready;
  logic                      start = 1'b0;
  logic                      busy;
  logic [COORD_BITS-1:0]     column = '0;
  logic [COORD_BITS-1:0]     row = '0;
  logic [DEPTH_W-1:0]        depth_mm = '0;
  logic [COLOR_W-1:0]        red = '0;
  logic [COLOR_W-1:0]        green = '0;
  logic [COLOR_W-1:0]        blue = '0;
  logic                      done;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;
  logic signed [POINT_W-1:0] point_z;
  logic                      point_valid;
  logic [PCOLOR_W-1:0]       packed_color;

  point_t      pending_points[$];
  camera_cfg_t active_cfg = '{CENTER_X_RST, CENTER_Y_RST, RECIP_FOCAL_RST, RECIP_FOCAL_RST,
                              DEPTH_LIMIT_RST, 1'b0};
  int          mismatches = 0;
  int          idle_cycles = 0;

  reg_index_t all_regs[6] = '{REG_CENTER_X, REG_CENTER_Y, REG_RECIP_FOCAL_X,
                              REG_RECIP_FOCAL_Y, REG_DEPTH_LIMIT, REG_AXIS_SWAP};

  // reset settings: principal point (320, 240) px, focal about 500 px, limit 20000 mm
  directed_row_t directed_rows[DIRECTED_ROWS] = '{
    '{'{12'd320, 12'd240, 16'd1000, 8'h00, 8'h00, 8'h00}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd16000, 1'b1, 24'h000000}},
    // one pixel left of center at 1 mm floors to -1
    '{'{12'd319, 12'd240, 16'd1, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
      '{-32'sd1, 32'sd0, 32'sd16, 1'b1, 24'hFFFFFF}},
    '{'{12'd320, 12'd240, 16'd0, 8'h12, 8'h34, 8'h56}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd0, 1'b0, 24'h123456}},
    '{'{12'd320, 12'd240, 16'd20001, 8'hAB, 8'hCD, 8'hEF}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd0, 1'b0, 24'hABCDEF}},
    '{'{12'd320, 12'd240, 16'd20000, 8'h01, 8'h02, 8'h03}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd320000, 1'b1, 24'h010203}},
    '{'{12'd0, 12'd4095, 16'd65535, 8'h80, 8'h40, 8'h20}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd0, 1'b0, 24'h804020}},
    '{'{12'd0, 12'd0, 16'd20000, 8'h11, 8'h22, 8'h33}, 1'b0, '0},
    '{'{12'd4095, 12'd4095, 16'd20000, 8'h44, 8'h55, 8'h66}, 1'b0, '0},
    '{'{12'd4095, 12'd0, 16'd1, 8'h77, 8'h88, 8'h99}, 1'b0, '0},
    '{'{12'hAAA, 12'h555, 16'h5555, 8'hAA, 8'h55, 8'hAA}, 1'b0, '0},
    '{'{12'h555, 12'hAAA, 16'h2AAA, 8'h55, 8'hAA, 8'h55}, 1'b0, '0},
    '{'{12'd321, 12'd239, 16'd19999, 8'h0F, 8'hF0, 8'h3C}, 1'b0, '0},
    '{'{12'd2048, 12'd2048, 16'd1234, 8'hC3, 8'h5A, 8'hE1}, 1'b0, '0}
  };

  // saturation both ways, axis swap, zero reciprocals, empty depth range
  camera_cfg_t preset_cfgs[PRESET_PHASES] = '{
    '{16'h0000, 16'h0000, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b0},
    '{16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1},
    '{16'h0000, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1},
    '{16'd8000, 16'd8000, 24'h000000, 24'h000000, 16'd1, 1'b1},
    '{CENTER_X_RST, CENTER_Y_RST, RECIP_FOCAL_RST, RECIP_FOCAL_RST, 16'd0, 1'b0}
  };

  depth_pixel_back_projection #(.COORD_BITS(COORD_BITS)) uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .column(column), .row(row), .depth_mm(depth_mm),
    .red(red), .green(green), .blue(blue),
    .done(done), .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .point_valid(point_valid), .packed_color(packed_color)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // floor(d * z * r / 2^24), exact
  function automatic longint floor_scaled(longint d, longint z, longint r);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = (d < 0) ? -d : d;
    prod = mag * z * r;
    if (d < 0) return -longint'((prod + 64'hFFFFFF) >> FRAC_BITS);
    return longint'(prod >> FRAC_BITS);
  endfunction

  function automatic logic signed [POINT_W-1:0] clamp_point(longint v);
    if (v > POINT_MAX) return POINT_MAX[POINT_W-1:0];
    if (v < POINT_MIN) return POINT_MIN[POINT_W-1:0];
    return v[POINT_W-1:0];
  endfunction

  function automatic point_t project_pixel(pixel_t px);
    point_t pt;
    longint du;
    longint dv;
    longint xf;
    longint yf;
    longint zf;
    pt       = '0;
    pt.color = {px.red, px.green, px.blue};
    pt.valid = (px.depth != 0) && (px.depth <= active_cfg.depth_limit);
    if (pt.valid) begin
      du = longint'({px.column, 4'b0000}) - longint'(active_cfg.center_x);
      dv = longint'({px.row, 4'b0000}) - longint'(active_cfg.center_y);
      xf = floor_scaled(du, px.depth, active_cfg.recip_x);
      yf = floor_scaled(dv, px.depth, active_cfg.recip_y);
      zf = longint'(px.depth) * 16;
      if (active_cfg.axis_swap) begin
        pt.x = clamp_point(zf);
        pt.y = clamp_point(-xf);
        pt.z = clamp_point(-yf);
      end else begin
        pt.x = clamp_point(xf);
        pt.y = clamp_point(yf);
        pt.z = clamp_point(zf);
      end
    end
    return pt;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] field_of(camera_cfg_t c, reg_index_t idx);
    case (idx)
      REG_CENTER_X:      return CFG_DATA_W'(c.center_x);
      REG_CENTER_Y:      return CFG_DATA_W'(c.center_y);
      REG_RECIP_FOCAL_X: return CFG_DATA_W'(c.recip_x);
      REG_RECIP_FOCAL_Y: return CFG_DATA_W'(c.recip_y);
      REG_DEPTH_LIMIT:   return CFG_DATA_W'(c.depth_limit);
      REG_AXIS_SWAP:     return CFG_DATA_W'(c.axis_swap);
      default:           return '0;
    endcase
  endfunction

  task automatic cfg_write(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << 2;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CENTER_X:      active_cfg.center_x    = val[CENTER_W-1:0];
      REG_CENTER_Y:      active_cfg.center_y    = val[CENTER_W-1:0];
      REG_RECIP_FOCAL_X: active_cfg.recip_x     = val[RECIP_W-1:0];
      REG_RECIP_FOCAL_Y: active_cfg.recip_y     = val[RECIP_W-1:0];
      REG_DEPTH_LIMIT:   active_cfg.depth_limit = val[DEPTH_W-1:0];
      REG_AXIS_SWAP:     active_cfg.axis_swap   = val[0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_readback(reg_index_t idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(idx) << 2;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== field_of(active_cfg, idx))
      report_mismatch($sformatf("register %0d readback", idx), prdata,
                      field_of(active_cfg, idx));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // program every register, junk above each field's width, then read all back
  task automatic load_camera(camera_cfg_t c);
    logic [CFG_DATA_W-1:0] val;
    foreach (all_regs[i]) begin
      val = field_of(c, all_regs[i]);
      case (all_regs[i])
        REG_RECIP_FOCAL_X, REG_RECIP_FOCAL_Y:
          val[CFG_DATA_W-1:RECIP_W] = (CFG_DATA_W - RECIP_W)'($urandom);
        REG_AXIS_SWAP:
          val[CFG_DATA_W-1:1] = (CFG_DATA_W - 1)'($urandom);
        default:
          val[CFG_DATA_W-1:CENTER_W] = (CFG_DATA_W - CENTER_W)'($urandom);
      endcase
      cfg_write(all_regs[i], val);
    end
    foreach (all_regs[i]) cfg_readback(all_regs[i]);
  endtask

  task automatic send_pixel(pixel_t px, logic typed, point_t typed_want, int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start    <= 1'b1;
    column   <= px.column;
    row      <= px.row;
    depth_mm <= px.depth;
    red      <= px.red;
    green    <= px.green;
    blue     <= px.blue;
    do @(posedge clk); while (busy);
    pending_points.push_back(typed ? typed_want : project_pixel(px));
  endtask

  // stop feeding and let the pipeline empty
  task automatic drain_pipeline();
    @(negedge clk);
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  function automatic logic [DEPTH_W-1:0] random_depth();
    logic [DEPTH_W-1:0] lim;
    lim = active_cfg.depth_limit;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return (lim != 16'hFFFF) ? DEPTH_W'($urandom_range(lim + 1, 65535)) : 16'hFFFF;
      2:       return DEPTH_W'($urandom_range(0, 65535));
      default: return (lim == 0) ? '0 : DEPTH_W'($urandom_range(1, lim));
    endcase
  endfunction

  function automatic logic [RECIP_W-1:0] random_recip();
    case ($urandom_range(0, 3))
      0:       return RECIP_W'($urandom_range(1, 65536));
      1:       return RECIP_W'($urandom_range(16000, 70000));
      2:       return RECIP_W'($urandom);
      default: return RECIP_W'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic run_phase(camera_cfg_t c);
    pixel_t px;
    logic   no_gaps;
    logic [DEPTH_W-1:0] lim;
    load_camera(c);
    lim     = active_cfg.depth_limit;
    no_gaps = ($urandom_range(0, 2) == 0);
    for (int k = 0; k < 8 + PHASE_RANDOM; k++) begin
      px = pixel_t'({$urandom, $urandom});
      px.depth = random_depth();
      case (k)
        0: px = '{12'd0, 12'd0, lim, px.red, px.green, px.blue};
        1: px = '{12'd4095, 12'd4095, lim, px.red, px.green, px.blue};
        2: px = '{12'd0, 12'd4095, 16'hFFFF, px.red, px.green, px.blue};
        3: px = '{12'd4095, 12'd0, 16'd1, px.red, px.green, px.blue};
        4: px = '{active_cfg.center_x[15:4], active_cfg.center_y[15:4], lim,
                  px.red, px.green, px.blue};
        5: px.depth = '0;
        6: px = '{12'd4095, 12'd4095, (lim == 16'hFFFF) ? lim : lim + 16'd1,
                  px.red, px.green, px.blue};
        7: px = '{12'd0, 12'd0, 16'hFFFF, px.red, px.green, px.blue};
        default: ;
      endcase
      send_pixel(px, 1'b0, '0, no_gaps ? 0 : $urandom_range(0, 17));
    end
    drain_pipeline();
  endtask

  initial begin
    camera_cfg_t c;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    foreach (all_regs[i]) cfg_readback(all_regs[i]);
    foreach (directed_rows[i])
      send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want,
                 $urandom_range(0, 17));
    drain_pipeline();
    foreach (preset_cfgs[i]) run_phase(preset_cfgs[i]);
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      c.center_x    = CENTER_W'($urandom_range(0, 65535));
      c.center_y    = CENTER_W'($urandom_range(0, 65535));
      c.recip_x     = random_recip();
      c.recip_y     = random_recip();
      c.depth_limit = ($urandom_range(0, 3) == 0) ? DEPTH_W'($urandom_range(0, 65535))
                                                  : DEPTH_W'($urandom_range(5000, 65535));
      c.axis_swap   = 1'($urandom_range(0, 1));
      run_phase(c);
    end
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // every strobed point must match the oldest pending one
  always @(posedge clk) begin : point_check
    point_t want;
    if (!rst && done) begin
      if (pending_points.size() == 0) begin
        report_mismatch("point with nothing pending, point_x", point_x, 0);
      end else begin
        want = pending_points.pop_front();
        if (point_x !== want.x) report_mismatch("point_x", point_x, want.x);
        if (point_y !== want.y) report_mismatch("point_y", point_y, want.y);
        if (point_z !== want.z) report_mismatch("point_z", point_z, want.z);
        if (point_valid !== want.valid) report_mismatch("point_valid", point_valid, want.valid);
        if (packed_color !== want.color)
          report_mismatch("packed_color", packed_color, want.color);
      end
    end
  end

  // no transfer of any kind for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
